@@ design/bprs_pkg.sv @@
// Package for the priority bitmap ready-queue scheduler.
// Holds field widths, operation and status codes, request and result types,
// and the command and read-data structs shared by the two stores.
package bprs_pkg;

  localparam int TID_W  = 5;
  localparam int PRIO_W = 5;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;
  localparam int MASK_W = 32;

  localparam int DEF_PRIORITY_LEVELS = 32;
  localparam int DEF_THREAD_SLOTS    = 32;

  localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE   = 2'd1;
  localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_INS_DUP  = 2'd1;
  localparam logic [ST_W-1:0] ST_REM_MISS = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TID_W-1:0]  thread_id;
    logic [PRIO_W-1:0] priority_req;
  } bprs_req_t;

  typedef struct packed {
    logic              switched;
    logic [TID_W-1:0]  chosen_thread;
    logic [PRIO_W-1:0] chosen_priority;
    logic [ST_W-1:0]   status;
    logic [MASK_W-1:0] ready_bits;
  } bprs_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_LINK,
    S_INS_OWN,
    S_REM_THR,
    S_REM_LVL,
    S_REM_FIX,
    S_SCH,
    S_RESULT
  } bprs_state_e;

  typedef struct packed {
    logic [TID_W-1:0] head;
    logic [TID_W-1:0] tail;
  } lvl_ent_t;

  typedef struct packed {
    logic [TID_W-1:0]  next;
    logic [TID_W-1:0]  prev;
    logic [PRIO_W-1:0] prio;
  } thr_ent_t;

  typedef struct packed {
    logic              rd_en;
    logic [PRIO_W-1:0] rd_lvl;
    logic              wr_head;
    logic              wr_tail;
    logic [PRIO_W-1:0] wr_lvl;
    lvl_ent_t          ent;
    logic              set_bit;
    logic              clr_bit;
    logic [PRIO_W-1:0] bit_lvl;
  } lvl_cmd_t;

  typedef struct packed {
    logic             rd_en;
    logic [TID_W-1:0] rd_tid;
    logic             wr_next;
    logic             wr_prev;
    logic             wr_prio;
    logic [TID_W-1:0] wr_tid;
    thr_ent_t         ent;
    logic             set_rdy;
    logic             clr_rdy;
    logic [TID_W-1:0] rdy_tid;
    logic [TID_W-1:0] q_tid;
  } thr_cmd_t;

endpackage

@@ design/bprs_lvl_store.sv @@
// Per-level store: head/tail memory, ready bitmap and lowest-set-bit finder.
// Depends on bprs_pkg.
module bprs_lvl_store #(
  parameter int PRIORITY_LEVELS = bprs_pkg::DEF_PRIORITY_LEVELS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bprs_pkg::lvl_cmd_t           cmd_i,
  output bprs_pkg::lvl_ent_t           rd_o,
  output logic [PRIORITY_LEVELS-1:0]   mask_o,
  output logic [PRIORITY_LEVELS-1:0]   mask_nxt_o,
  output logic [bprs_pkg::PRIO_W-1:0]  low_o,
  output logic                         any_o
);

  localparam int LA = $clog2(PRIORITY_LEVELS);

  bprs_pkg::lvl_ent_t             mem [PRIORITY_LEVELS];
  bprs_pkg::lvl_ent_t             rd_q;
  logic [PRIORITY_LEVELS-1:0]     mask_q;
  logic [PRIORITY_LEVELS-1:0]     mask_d;
  logic [PRIORITY_LEVELS-1:0]     bit_sel;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_head) begin
      mem[LA'(cmd_i.wr_lvl)].head <= cmd_i.ent.head;
    end
    if (cmd_i.wr_tail) begin
      mem[LA'(cmd_i.wr_lvl)].tail <= cmd_i.ent.tail;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[LA'(cmd_i.rd_lvl)];
    end
  end

  assign bit_sel = PRIORITY_LEVELS'(1) << LA'(cmd_i.bit_lvl);

  always_comb begin
    mask_d = mask_q;
    if (cmd_i.set_bit) begin
      mask_d = mask_q | bit_sel;
    end else if (cmd_i.clr_bit) begin
      mask_d = mask_q & ~bit_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_comb begin
    low_o = '0;
    for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        low_o = bprs_pkg::PRIO_W'(i);
      end
    end
  end

  assign any_o      = |mask_q;
  assign mask_o     = mask_q;
  assign mask_nxt_o = mask_d;
  assign rd_o       = rd_q;

endmodule

@@ design/bprs_thr_store.sv @@
// Per-thread store: next/prev/priority memory and thread ready flags.
// Depends on bprs_pkg.
module bprs_thr_store #(
  parameter int THREAD_SLOTS = bprs_pkg::DEF_THREAD_SLOTS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bprs_pkg::thr_cmd_t cmd_i,
  output bprs_pkg::thr_ent_t rd_o,
  output logic               rdy_o
);

  localparam int TA = $clog2(THREAD_SLOTS);

  bprs_pkg::thr_ent_t mem [THREAD_SLOTS];
  bprs_pkg::thr_ent_t rd_q;
  logic               rdy_q [THREAD_SLOTS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_next) begin
      mem[TA'(cmd_i.wr_tid)].next <= cmd_i.ent.next;
    end
    if (cmd_i.wr_prev) begin
      mem[TA'(cmd_i.wr_tid)].prev <= cmd_i.ent.prev;
    end
    if (cmd_i.wr_prio) begin
      mem[TA'(cmd_i.wr_tid)].prio <= cmd_i.ent.prio;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[TA'(cmd_i.rd_tid)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < THREAD_SLOTS; i++) begin
        rdy_q[i] <= 1'b0;
      end
    end else if (cmd_i.set_rdy) begin
      rdy_q[TA'(cmd_i.rdy_tid)] <= 1'b1;
    end else if (cmd_i.clr_rdy) begin
      rdy_q[TA'(cmd_i.rdy_tid)] <= 1'b0;
    end
  end

  assign rdy_o = rdy_q[TA'(cmd_i.q_tid)];
  assign rd_o  = rd_q;

endmodule

@@ design/bitmap_priority_ready_scheduler.sv @@
// Top level of the priority bitmap ready-queue scheduler: request sequencer,
// result register and the two stores. Depends on bprs_pkg, bprs_lvl_store,
// bprs_thr_store.
//
//   channel  | signals                          | payload
//   request  | in_valid_i / in_ready_o          | in_data_i  (bprs_req_t)
//   result   | out_valid_o / out_ready_i        | out_data_o (bprs_rsp_t)
//
// One request at a time; one result per request, held in a result register.
// Steps: schedule S_SCH; insert S_INS_OWN (empty level) or S_INS_LINK then
// S_INS_OWN; remove S_REM_THR, S_REM_LVL, and S_REM_FIX for a middle thread;
// refused, empty or undefined S_RESULT. Registered reads and a single write
// port per store set the steps; a full result register stalls the last one.
// Reset clears the bitmap, the thread ready flags and the current thread.
module bitmap_priority_ready_scheduler #(
  parameter int PRIORITY_LEVELS = bprs_pkg::DEF_PRIORITY_LEVELS,
  parameter int THREAD_SLOTS    = bprs_pkg::DEF_THREAD_SLOTS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bprs_pkg::bprs_req_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bprs_pkg::bprs_rsp_t out_data_o
);

  localparam int LA = $clog2(PRIORITY_LEVELS);

  bprs_pkg::bprs_state_e state_q, state_d;

  bprs_pkg::lvl_cmd_t lvl_cmd;
  bprs_pkg::lvl_ent_t lvl_rd;
  bprs_pkg::thr_cmd_t thr_cmd;
  bprs_pkg::thr_ent_t thr_rd;

  logic [PRIORITY_LEVELS-1:0]  mask_q;
  logic [PRIORITY_LEVELS-1:0]  mask_nxt;
  logic [bprs_pkg::PRIO_W-1:0] low;
  logic                        any;
  logic                        thr_rdy;

  logic [bprs_pkg::TID_W-1:0]  tid_q;
  logic [bprs_pkg::PRIO_W-1:0] prio_q;
  logic [bprs_pkg::TID_W-1:0]  link_q;
  logic [bprs_pkg::TID_W-1:0]  nx_q;
  logic [bprs_pkg::ST_W-1:0]   status_q;
  logic                        nonempty_q;

  logic                        cur_valid_q;
  logic [bprs_pkg::TID_W-1:0]  cur_thread_q;
  logic [bprs_pkg::PRIO_W-1:0] cur_prio_q;

  logic                        out_valid_q;
  bprs_pkg::bprs_rsp_t         out_q;

  logic                        in_acc;
  logic                        out_free;
  logic                        tid_ok;
  logic [bprs_pkg::PRIO_W-1:0] psat;
  logic                        lvl_bit;
  logic                        is_head;
  logic                        is_tail;
  logic                        need_fix;
  logic                        sch_sw;
  logic                        done;

  bprs_lvl_store #(
    .PRIORITY_LEVELS(PRIORITY_LEVELS)
  ) u_lvl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (lvl_cmd),
    .rd_o       (lvl_rd),
    .mask_o     (mask_q),
    .mask_nxt_o (mask_nxt),
    .low_o      (low),
    .any_o      (any)
  );

  bprs_thr_store #(
    .THREAD_SLOTS(THREAD_SLOTS)
  ) u_thr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (thr_cmd),
    .rd_o   (thr_rd),
    .rdy_o  (thr_rdy)
  );

  assign in_ready_o = (state_q == bprs_pkg::S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign tid_ok  = {27'd0, in_data_i.thread_id} < 32'(THREAD_SLOTS);
  assign psat    = ({27'd0, in_data_i.priority_req} >= 32'(PRIORITY_LEVELS)) ?
                   bprs_pkg::PRIO_W'(PRIORITY_LEVELS - 1) : in_data_i.priority_req;
  assign lvl_bit = mask_q[LA'(psat)];

  assign is_head  = (lvl_rd.head == tid_q);
  assign is_tail  = (lvl_rd.tail == tid_q);
  assign need_fix = !is_head && !is_tail;
  assign sch_sw   = !cur_valid_q || (lvl_rd.head != cur_thread_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      bprs_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_data_i.op)
            bprs_pkg::OP_INSERT: begin
              if (!tid_ok || thr_rdy) begin
                state_d = bprs_pkg::S_RESULT;
              end else if (lvl_bit) begin
                state_d = bprs_pkg::S_INS_LINK;
              end else begin
                state_d = bprs_pkg::S_INS_OWN;
              end
            end
            bprs_pkg::OP_REMOVE: begin
              state_d = (!tid_ok || !thr_rdy) ? bprs_pkg::S_RESULT : bprs_pkg::S_REM_THR;
            end
            bprs_pkg::OP_SCHEDULE: begin
              state_d = any ? bprs_pkg::S_SCH : bprs_pkg::S_RESULT;
            end
            default: state_d = bprs_pkg::S_RESULT;
          endcase
        end
      end
      bprs_pkg::S_INS_LINK: state_d = bprs_pkg::S_INS_OWN;
      bprs_pkg::S_REM_THR:  state_d = bprs_pkg::S_REM_LVL;
      bprs_pkg::S_REM_LVL: begin
        if (need_fix) begin
          state_d = bprs_pkg::S_REM_FIX;
        end else if (out_free) begin
          state_d = bprs_pkg::S_IDLE;
        end
      end
      bprs_pkg::S_INS_OWN, bprs_pkg::S_REM_FIX, bprs_pkg::S_SCH, bprs_pkg::S_RESULT: begin
        if (out_free) begin
          state_d = bprs_pkg::S_IDLE;
        end
      end
      default: state_d = bprs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    lvl_cmd       = '0;
    thr_cmd       = '0;
    thr_cmd.q_tid = in_data_i.thread_id;
    done          = 1'b0;
    case (state_q)
      bprs_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_data_i.op)
            bprs_pkg::OP_INSERT: begin
              lvl_cmd.rd_en  = tid_ok && !thr_rdy && lvl_bit;
              lvl_cmd.rd_lvl = psat;
            end
            bprs_pkg::OP_REMOVE: begin
              thr_cmd.rd_en  = tid_ok && thr_rdy;
              thr_cmd.rd_tid = in_data_i.thread_id;
            end
            bprs_pkg::OP_SCHEDULE: begin
              lvl_cmd.rd_en  = any;
              lvl_cmd.rd_lvl = low;
            end
            default: ;
          endcase
        end
      end
      bprs_pkg::S_INS_LINK: begin
        thr_cmd.wr_next  = 1'b1;
        thr_cmd.wr_tid   = lvl_rd.tail;
        thr_cmd.ent.next = tid_q;
      end
      bprs_pkg::S_INS_OWN: begin
        done             = out_free;
        thr_cmd.wr_tid   = tid_q;
        thr_cmd.wr_prio  = out_free;
        thr_cmd.ent.prio = prio_q;
        thr_cmd.wr_prev  = out_free && nonempty_q;
        thr_cmd.ent.prev = link_q;
        thr_cmd.set_rdy  = out_free;
        thr_cmd.rdy_tid  = tid_q;
        lvl_cmd.wr_lvl   = prio_q;
        lvl_cmd.wr_tail  = out_free;
        lvl_cmd.wr_head  = out_free && !nonempty_q;
        lvl_cmd.ent.head = tid_q;
        lvl_cmd.ent.tail = tid_q;
        lvl_cmd.set_bit  = out_free;
        lvl_cmd.bit_lvl  = prio_q;
      end
      bprs_pkg::S_REM_THR: begin
        lvl_cmd.rd_en  = 1'b1;
        lvl_cmd.rd_lvl = thr_rd.prio;
      end
      bprs_pkg::S_REM_LVL: begin
        done             = !need_fix && out_free;
        lvl_cmd.wr_lvl   = prio_q;
        lvl_cmd.bit_lvl  = prio_q;
        lvl_cmd.ent.head = nx_q;
        lvl_cmd.ent.tail = link_q;
        lvl_cmd.clr_bit  = out_free && is_head && is_tail;
        lvl_cmd.wr_head  = out_free && is_head && !is_tail;
        lvl_cmd.wr_tail  = out_free && !is_head && is_tail;
        thr_cmd.wr_next  = need_fix || (out_free && !is_head);
        thr_cmd.wr_tid   = link_q;
        thr_cmd.ent.next = nx_q;
        thr_cmd.clr_rdy  = done;
        thr_cmd.rdy_tid  = tid_q;
      end
      bprs_pkg::S_REM_FIX: begin
        done             = out_free;
        thr_cmd.wr_prev  = out_free;
        thr_cmd.wr_tid   = nx_q;
        thr_cmd.ent.prev = link_q;
        thr_cmd.clr_rdy  = out_free;
        thr_cmd.rdy_tid  = tid_q;
      end
      bprs_pkg::S_SCH, bprs_pkg::S_RESULT: begin
        done = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bprs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      bprs_pkg::S_IDLE: begin
        if (in_acc) begin
          tid_q      <= in_data_i.thread_id;
          nonempty_q <= lvl_bit;
          status_q   <= bprs_pkg::ST_OK;
          prio_q     <= psat;
          case (in_data_i.op)
            bprs_pkg::OP_INSERT: begin
              if (!tid_ok || thr_rdy) begin
                status_q <= bprs_pkg::ST_INS_DUP;
              end
            end
            bprs_pkg::OP_REMOVE: begin
              if (!tid_ok || !thr_rdy) begin
                status_q <= bprs_pkg::ST_REM_MISS;
              end
            end
            bprs_pkg::OP_SCHEDULE: begin
              prio_q <= low;
              if (!any) begin
                status_q <= bprs_pkg::ST_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      bprs_pkg::S_INS_LINK: begin
        link_q <= lvl_rd.tail;
      end
      bprs_pkg::S_REM_THR: begin
        prio_q <= thr_rd.prio;
        nx_q   <= thr_rd.next;
        link_q <= thr_rd.prev;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q  <= 1'b0;
      cur_thread_q <= '0;
      cur_prio_q   <= bprs_pkg::PRIO_W'(PRIORITY_LEVELS - 1);
    end else if ((state_q == bprs_pkg::S_SCH) && done && sch_sw) begin
      cur_valid_q  <= 1'b1;
      cur_thread_q <= lvl_rd.head;
      cur_prio_q   <= prio_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q.switched   <= (state_q == bprs_pkg::S_SCH) && sch_sw;
      out_q.status     <= status_q;
      out_q.ready_bits <= bprs_pkg::MASK_W'(mask_nxt);
      if ((state_q == bprs_pkg::S_SCH) && sch_sw) begin
        out_q.chosen_thread   <= lvl_rd.head;
        out_q.chosen_priority <= prio_q;
      end else begin
        out_q.chosen_thread   <= cur_thread_q;
        out_q.chosen_priority <= cur_prio_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  a_sched_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bprs_pkg::S_SCH) |-> (mask_q != '0))
    else $error("schedule lookup with an empty bitmap");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && out_valid_q) |-> out_ready_i)
    else $error("result register overwritten before it was taken");

endmodule

@@ tb/sv/bitmap_priority_ready_scheduler_test.sv @@
// Self-checking test of the priority bitmap ready-queue scheduler: directed
// and random requests, each result checked against an in-bench scheduler model.
// Depends on bprs_pkg and bitmap_priority_ready_scheduler.
module bitmap_priority_ready_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bprs_pkg::*;

  localparam int LEVELS = DEF_PRIORITY_LEVELS;
  localparam int SLOTS = DEF_THREAD_SLOTS;
  localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;
  localparam logic [MASK_W-1:0] LEVEL_MASK = {MASK_W{1'b1}} >> (MASK_W - LEVELS);
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  bprs_req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  bprs_rsp_t out_data_o;

  int send_idle_pct = 9;
  int recv_idle_pct = 48;
  int err_count = 0;
  int stall_cycles = 0;

  bprs_rsp_t pending_rsp_q[$];

  logic [MASK_W-1:0] ready_map;
  logic [TID_W-1:0] lvl_head [LEVELS];
  logic [TID_W-1:0] lvl_tail [LEVELS];
  logic [TID_W-1:0] thr_next [SLOTS];
  logic [TID_W-1:0] thr_prev [SLOTS];
  logic [PRIO_W-1:0] thr_level [SLOTS];
  logic thr_ready [SLOTS];
  logic cur_valid;
  logic [TID_W-1:0] cur_tid;
  logic [PRIO_W-1:0] cur_prio;

  bitmap_priority_ready_scheduler #(
    .PRIORITY_LEVELS(LEVELS),
    .THREAD_SLOTS(SLOTS)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void sched_reset();
    ready_map = '0;
    for (int i = 0; i < LEVELS; i++) begin
      lvl_head[i] = '0;
      lvl_tail[i] = '0;
    end
    for (int i = 0; i < SLOTS; i++) begin
      thr_next[i] = '0;
      thr_prev[i] = '0;
      thr_level[i] = '0;
      thr_ready[i] = 1'b0;
    end
    cur_valid = 1'b0;
    cur_tid = '0;
    cur_prio = PRIO_W'(LEVELS - 1);
  endfunction

  function automatic bprs_rsp_t sched_predict(bprs_req_t rq);
    bprs_rsp_t rsp;
    logic [ST_W-1:0] st;
    logic sw;
    logic [MASK_W-1:0] m;
    int t, p, nx, pv, tl;
    st = ST_OK;
    sw = 1'b0;
    t = rq.thread_id;
    case (rq.op)
      OP_INSERT: begin
        if (t >= SLOTS || thr_ready[t]) begin
          st = ST_INS_DUP;
        end else begin
          p = rq.priority_req;
          if (p >= LEVELS) p = LEVELS - 1;
          if (ready_map[p]) begin
            tl = lvl_tail[p];
            thr_next[tl] = TID_W'(t);
            thr_prev[t] = TID_W'(tl);
          end else begin
            lvl_head[p] = TID_W'(t);
          end
          lvl_tail[p] = TID_W'(t);
          thr_level[t] = PRIO_W'(p);
          thr_ready[t] = 1'b1;
          ready_map[p] = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (t >= SLOTS || !thr_ready[t]) begin
          st = ST_REM_MISS;
        end else begin
          p = thr_level[t];
          nx = thr_next[t];
          pv = thr_prev[t];
          if (lvl_head[p] == t) begin
            if (lvl_tail[p] == t) ready_map[p] = 1'b0;
            else lvl_head[p] = TID_W'(nx);
          end else begin
            thr_next[pv] = TID_W'(nx);
            if (lvl_tail[p] == t) lvl_tail[p] = TID_W'(pv);
            else thr_prev[nx] = TID_W'(pv);
          end
          thr_ready[t] = 1'b0;
        end
      end
      OP_SCHEDULE: begin
        m = ready_map & LEVEL_MASK;
        if (m == '0) begin
          st = ST_EMPTY;
        end else begin
          p = 0;
          while (!m[p]) p++;
          if (!cur_valid || lvl_head[p] != cur_tid) begin
            cur_valid = 1'b1;
            cur_tid = lvl_head[p];
            cur_prio = PRIO_W'(p);
            sw = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    rsp.switched = sw;
    rsp.chosen_thread = cur_tid;
    rsp.chosen_priority = cur_prio;
    rsp.status = st;
    rsp.ready_bits = ready_map;
    return rsp;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk_i) begin : rsp_check
    bprs_rsp_t want;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
    else stall_cycles++;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rsp_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data_o);
        err_count++;
      end else begin
        want = pending_rsp_q.pop_front();
        check_field("switched", want.switched, out_data_o.switched);
        check_field("chosen_thread", want.chosen_thread, out_data_o.chosen_thread);
        check_field("chosen_priority", want.chosen_priority, out_data_o.chosen_priority);
        check_field("status", want.status, out_data_o.status);
        check_field("ready_bits", want.ready_bits, out_data_o.ready_bits);
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_req(input logic [OP_W-1:0] op, input int tid, input int prio);
    bprs_req_t rq;
    rq.op = op;
    rq.thread_id = TID_W'(tid);
    rq.priority_req = PRIO_W'(prio);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= rq;
    do @(posedge clk_i); while (!in_ready_o);
    pending_rsp_q.push_back(sched_predict(rq));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic int pick_thread(bit want_ready);
    int start;
    int t;
    start = $urandom_range(SLOTS - 1);
    for (int i = 0; i < SLOTS; i++) begin
      t = (start + i) % SLOTS;
      if (thr_ready[t] == want_ready) return t;
    end
    return -1;
  endfunction

  task automatic test_idle_scheduler();
    send_req(OP_SCHEDULE, 0, 0);
    send_req(OP_REMOVE, 31, 0);
    send_req(OP_UNDEF, 31, 31);
  endtask

  task automatic test_insert_and_pick();
    send_req(OP_INSERT, 0, 31);
    send_req(OP_INSERT, 31, 0);
    send_req(OP_INSERT, 31, 5);
    send_req(OP_SCHEDULE, 0, 0);
    send_req(OP_SCHEDULE, 31, 31);
    send_req(OP_INSERT, 5, 0);
    send_req(OP_SCHEDULE, 0, 0);
    send_req(OP_REMOVE, 31, 0);
    send_req(OP_SCHEDULE, 0, 0);
  endtask

  task automatic test_unlink_positions();
    for (int t = 10; t < 14; t++) send_req(OP_INSERT, t, 7);
    send_req(OP_REMOVE, 11, 0);
    send_req(OP_REMOVE, 13, 0);
    send_req(OP_REMOVE, 10, 0);
    send_req(OP_REMOVE, 11, 0);
    send_req(OP_REMOVE, 12, 0);
    send_req(OP_REMOVE, 5, 0);
    send_req(OP_REMOVE, 0, 0);
    send_req(OP_SCHEDULE, 0, 0);
  endtask

  task automatic test_random_traffic(input int n, input int s_pct, input int r_pct);
    int r, tid, prio;
    logic [OP_W-1:0] op;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_drained();
      r = $urandom_range(99);
      tid = $urandom_range(SLOTS - 1);
      prio = $urandom_range(1) ? $urandom_range(3) : $urandom_range(LEVELS - 1);
      if (r < 35) begin
        op = OP_INSERT;
        if ($urandom_range(9) != 0 && pick_thread(1'b0) >= 0) tid = pick_thread(1'b0);
      end else if (r < 70) begin
        op = OP_REMOVE;
        if ($urandom_range(9) != 0 && pick_thread(1'b1) >= 0) tid = pick_thread(1'b1);
      end else if (r < 90) begin
        op = OP_SCHEDULE;
        prio = $urandom_range(31);
      end else begin
        op = OP_W'($urandom_range(3));
        prio = $urandom_range(31);
      end
      send_req(op, tid, prio);
    end
    wait_drained();
  endtask

  initial begin
    sched_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_scheduler();
    test_insert_and_pick();
    test_unlink_positions();
    wait_drained();
    test_random_traffic(RANDOM_PER_PHASE, 9, 48);
    test_random_traffic(RANDOM_PER_PHASE, 48, 9);
    test_random_traffic(RANDOM_PER_PHASE, 0, 0);
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
